[rtl/urfd_pkg.sv]
// ----------------------------------------------------------------------------
// urfd_pkg
// Shared types, widths, register indexes and the segment table of the
// ultrasonic range filter display unit.
// ----------------------------------------------------------------------------
package urfd_pkg;

    // echo counter and fixed-point widths
    localparam int COUNT_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int INT_BITS   = 12;
    localparam int FILT_W     = INT_BITS + FRAC_BITS;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = COUNT_BITS + COEF_W;
    localparam int DIST_W     = PROD_W + FRAC_BITS;

    // shared bit-serial multiplier
    localparam int MUL_W  = (COUNT_BITS > FILT_W) ? COUNT_BITS : FILT_W;
    localparam int MULP_W = MUL_W + COEF_W;
    localparam int STEP_W = $clog2(MUL_W + 1);

    // display and trigger timing
    localparam int PH_W      = 4;
    localparam int LIM_W     = 7;
    localparam int DIGIT_W   = 4;
    localparam int SEG_W     = 8;
    localparam int MAX_SHOWN = 99;

    // divide by ten for values below one hundred: (x * 205) >> 11
    localparam int DIV10_MUL   = 205;
    localparam int DIV10_SHIFT = 11;
    localparam int DIV10_W     = LIM_W + 8;

    // configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_RANGE_SCALE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLANK_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_HIGH = 3'd4;

    localparam logic [COEF_W-1:0] RST_RANGE_SCALE  = 16'd3378;
    localparam logic [COEF_W-1:0] RST_FILTER_GAIN  = 16'd655;
    localparam logic [LIM_W-1:0]  RST_BLANK_LIMIT  = 7'd31;
    localparam logic [PH_W-1:0]   RST_TRIGGER_LOW  = 4'd2;
    localparam logic [PH_W-1:0]   RST_TRIGGER_HIGH = 4'd10;

    // one microsecond tick
    typedef struct packed {
        logic echo;
        logic button_press;
    } tick_t;

    // one display result
    typedef struct packed {
        logic               trigger;
        logic               led;
        logic               new_reading;
        logic               blank;
        logic [LIM_W-1:0]   shown_cm;
        logic [SEG_W-1:0]   tens_segments;
        logic [SEG_W-1:0]   ones_segments;
        logic               tens_on;
        logic               ones_on;
    } result_t;

    // segment pattern of one decimal digit
    function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] code;
        unique case (digit)
            4'd0:    code = 8'h88;
            4'd1:    code = 8'hBE;
            4'd2:    code = 8'hC4;
            4'd3:    code = 8'hA4;
            4'd4:    code = 8'hB2;
            4'd5:    code = 8'hA1;
            4'd6:    code = 8'h83;
            4'd7:    code = 8'hBC;
            4'd8:    code = 8'h80;
            4'd9:    code = 8'hB0;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

[rtl/urfd_serial_mul.sv]
// ----------------------------------------------------------------------------
// urfd_serial_mul
// Bit-serial shift-add multiplier: one multiplier bit per cycle, a narrow
// adder of the multiplicand width, full product after MUL_W steps.
// ----------------------------------------------------------------------------
module urfd_serial_mul (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [urfd_pkg::COEF_W-1:0]       mcand,
    input  logic [urfd_pkg::MUL_W-1:0]        mplier,
    output logic                              done,
    output logic [urfd_pkg::MULP_W-1:0]       product
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [urfd_pkg::STEP_W-1:0]       steps_reg;
    logic [urfd_pkg::COEF_W-1:0]       mcand_reg;
    logic [urfd_pkg::COEF_W-1:0]       hi_reg;
    logic [urfd_pkg::MUL_W-1:0]        lo_reg;
    logic [urfd_pkg::COEF_W-1:0]       addend;
    logic [urfd_pkg::COEF_W:0]         sum_next;

    // add the multiplicand when the low multiplier bit is set
    always_comb
    begin
        addend   = lo_reg[0] ? mcand_reg : '0;
        sum_next = {1'b0, hi_reg} + {1'b0, addend};
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            steps_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                steps_reg <= urfd_pkg::STEP_W'(urfd_pkg::MUL_W);
            end
            else if (busy_reg)
            begin
                steps_reg <= steps_reg - 1'b1;
                if (steps_reg == urfd_pkg::STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // partial product shifts right one bit per step
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg <= mcand;
            hi_reg    <= '0;
            lo_reg    <= mplier;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum_next[urfd_pkg::COEF_W:1];
            lo_reg <= {sum_next[0], lo_reg[urfd_pkg::MUL_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

[rtl/ultrasonic_range_filter_display_unit.sv]
// ----------------------------------------------------------------------------
// ultrasonic_range_filter_display_unit
// Echo ranging sequencer with an exponential low-pass filter on the
// distance and a two-digit segment display of the filtered value.
//
//   channel  | direction | handshake                | payload
//   ---------+-----------+--------------------------+------------------------
//   tick     | in        | tick_valid / tick_stall  | urfd_pkg::tick_t
//   result   | out       | result_valid/result_stall| urfd_pkg::result_t
//   config   | in        | cfg_we                   | cfg_index, cfg_data
//
// An ordinary tick is accepted, then loaded into the result register.
// A tick that ends a measurement also runs the shared bit-serial
// multiplier twice (distance, then filter step) at 28 steps each.
// Reset clears the sequencer, filter and display state and loads the
// register defaults. The next tick is taken while a result waits; a stalled
// result only holds the unit once the following result is ready.
// ----------------------------------------------------------------------------
module ultrasonic_range_filter_display_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              tick_valid,
    output logic                              tick_stall,
    input  urfd_pkg::tick_t                   tick,
    output logic                              result_valid,
    input  logic                              result_stall,
    output urfd_pkg::result_t                 result,
    input  logic                              cfg_we,
    input  logic [urfd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [urfd_pkg::CFG_W-1:0]        cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RANGE,
        S_FILTER,
        S_UPDATE,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PH_TRIG_LOW,
        PH_TRIG_HIGH,
        PH_WAIT_ECHO,
        PH_COUNT
    } phase_t;

    // configuration registers
    logic [urfd_pkg::COEF_W-1:0]       range_scale_reg;
    logic [urfd_pkg::COEF_W-1:0]       filter_gain_reg;
    logic [urfd_pkg::LIM_W-1:0]        blank_limit_reg;
    logic [urfd_pkg::PH_W-1:0]         trigger_low_reg;
    logic [urfd_pkg::PH_W-1:0]         trigger_high_reg;

    // sequencer and filter state
    state_t                            state_reg;
    phase_t                            phase_reg;
    phase_t                            phase_next;
    logic                              paused_reg;
    logic                              paused_next;
    logic [urfd_pkg::PH_W-1:0]         phase_ticks_reg;
    logic [urfd_pkg::PH_W-1:0]         phase_ticks_next;
    logic [urfd_pkg::COUNT_BITS-1:0]   echo_ticks_reg;
    logic [urfd_pkg::COUNT_BITS-1:0]   echo_ticks_next;
    logic [urfd_pkg::FILT_W-1:0]       filtered_reg;
    logic                              dark_reg;
    logic                              dark_next;
    logic [urfd_pkg::LIM_W-1:0]        value_reg;
    logic                              trig_reg;
    logic                              trig_next;
    logic                              fresh_reg;
    logic                              measure_done;
    logic                              d_ge_reg;
    logic                              result_valid_reg;
    urfd_pkg::result_t                 result_reg;

    // phase timing
    logic [urfd_pkg::PH_W:0]           tick_cnt;
    logic [urfd_pkg::PH_W-1:0]         phase_len;
    logic                              tick_accept;

    // distance and filter datapath
    logic                              mul_start;
    logic                              mul_done;
    logic [urfd_pkg::COEF_W-1:0]       mul_mcand;
    logic [urfd_pkg::MUL_W-1:0]        mul_mplier;
    logic [urfd_pkg::MULP_W-1:0]       mul_product;
    logic [urfd_pkg::PROD_W-1:0]       raw_dist;
    logic [urfd_pkg::DIST_W-1:0]       dist_wide;
    logic [urfd_pkg::FILT_W-1:0]       dist_sat;
    logic [urfd_pkg::FILT_W:0]         dist_sub;
    logic                              d_ge;
    logic [urfd_pkg::FILT_W-1:0]       diff;
    logic [urfd_pkg::FILT_W-1:0]       step;
    logic [urfd_pkg::FILT_W-1:0]       filtered_next;
    logic [urfd_pkg::LIM_W-1:0]        limit;
    logic [urfd_pkg::INT_BITS-1:0]     filt_int;
    logic                              over_limit;

    // display digits
    logic                              blank_now;
    logic [urfd_pkg::LIM_W-1:0]        shown;
    logic [urfd_pkg::DIV10_W-1:0]      tens_prod;
    logic [urfd_pkg::DIGIT_W-1:0]      tens;
    logic [urfd_pkg::LIM_W-1:0]        tens_x10;
    logic [urfd_pkg::DIGIT_W-1:0]      ones;
    logic                              tens_lit;
    logic                              ones_lit;
    logic                              emit_go;

    assign tick_accept = tick_valid && (state_reg == S_IDLE);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_scale_reg  <= urfd_pkg::RST_RANGE_SCALE;
            filter_gain_reg  <= urfd_pkg::RST_FILTER_GAIN;
            blank_limit_reg  <= urfd_pkg::RST_BLANK_LIMIT;
            trigger_low_reg  <= urfd_pkg::RST_TRIGGER_LOW;
            trigger_high_reg <= urfd_pkg::RST_TRIGGER_HIGH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                urfd_pkg::REG_RANGE_SCALE:  range_scale_reg  <= cfg_data;
                urfd_pkg::REG_FILTER_GAIN:  filter_gain_reg  <= cfg_data;
                urfd_pkg::REG_BLANK_LIMIT:  blank_limit_reg  <= cfg_data[urfd_pkg::LIM_W-1:0];
                urfd_pkg::REG_TRIGGER_LOW:  trigger_low_reg  <= cfg_data[urfd_pkg::PH_W-1:0];
                urfd_pkg::REG_TRIGGER_HIGH: trigger_high_reg <= cfg_data[urfd_pkg::PH_W-1:0];
                default: ;
            endcase
        end
    end

    // run/pause toggle and trigger/echo phase sequencing for one tick
    always_comb
    begin
        paused_next      = paused_reg ^ tick.button_press;
        phase_next       = phase_reg;
        phase_ticks_next = phase_ticks_reg;
        echo_ticks_next  = echo_ticks_reg;
        dark_next        = dark_reg;
        trig_next        = 1'b0;
        measure_done     = 1'b0;
        tick_cnt         = '0;
        phase_len        = '0;

        if (tick.button_press)
        begin
            phase_next       = PH_TRIG_LOW;
            phase_ticks_next = '0;
            echo_ticks_next  = '0;
            if (paused_next)
            begin
                dark_next = 1'b1;
            end
        end

        if (paused_next)
        begin
            phase_next       = PH_TRIG_LOW;
            phase_ticks_next = '0;
            echo_ticks_next  = '0;
        end
        else
        begin
            unique case (phase_next)
                PH_TRIG_LOW, PH_TRIG_HIGH:
                begin
                    trig_next = (phase_next == PH_TRIG_HIGH);
                    tick_cnt  = {1'b0, phase_ticks_next} + 1'b1;
                    phase_len = trig_next ? trigger_high_reg : trigger_low_reg;
                    if (tick_cnt >= {1'b0, phase_len})
                    begin
                        phase_next       = trig_next ? PH_WAIT_ECHO : PH_TRIG_HIGH;
                        phase_ticks_next = '0;
                    end
                    else
                    begin
                        phase_ticks_next = tick_cnt[urfd_pkg::PH_W-1:0];
                    end
                end
                PH_WAIT_ECHO:
                begin
                    if (tick.echo)
                    begin
                        phase_next      = PH_COUNT;
                        echo_ticks_next = urfd_pkg::COUNT_BITS'(1);
                    end
                end
                PH_COUNT:
                begin
                    if (tick.echo)
                    begin
                        if (echo_ticks_next != '1)
                        begin
                            echo_ticks_next = echo_ticks_next + 1'b1;
                        end
                    end
                    else
                    begin
                        measure_done     = 1'b1;
                        phase_next       = PH_TRIG_LOW;
                        phase_ticks_next = '0;
                        echo_ticks_next  = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // multiplier operands: distance first, then the filter step
    assign mul_start  = (tick_accept && measure_done) || ((state_reg == S_RANGE) && mul_done);
    assign mul_mcand  = (state_reg == S_IDLE) ? range_scale_reg : filter_gain_reg;
    assign mul_mplier = (state_reg == S_IDLE) ? urfd_pkg::MUL_W'(echo_ticks_reg)
                                              : urfd_pkg::MUL_W'(diff);

    urfd_serial_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .done    (mul_done),
        .product (mul_product)
    );

    // distance in filter format, saturated, and its distance to the filter
    always_comb
    begin
        raw_dist  = mul_product[urfd_pkg::PROD_W-1:0];
        dist_wide = {raw_dist, {urfd_pkg::FRAC_BITS{1'b0}}} >> urfd_pkg::COEF_W;
        dist_sat  = (|dist_wide[urfd_pkg::DIST_W-1:urfd_pkg::FILT_W])
                    ? '1 : dist_wide[urfd_pkg::FILT_W-1:0];
        dist_sub  = {1'b0, dist_sat} - {1'b0, filtered_reg};
        d_ge      = !dist_sub[urfd_pkg::FILT_W];
        diff      = d_ge ? dist_sub[urfd_pkg::FILT_W-1:0] : (filtered_reg - dist_sat);
    end

    // filter step and limit check
    always_comb
    begin
        step          = mul_product[urfd_pkg::FILT_W+urfd_pkg::COEF_W-1:urfd_pkg::COEF_W];
        filtered_next = d_ge_reg ? (filtered_reg + step) : (filtered_reg - step);
        limit         = (blank_limit_reg > urfd_pkg::LIM_W'(urfd_pkg::MAX_SHOWN))
                        ? urfd_pkg::LIM_W'(urfd_pkg::MAX_SHOWN) : blank_limit_reg;
        filt_int      = filtered_reg[urfd_pkg::FILT_W-1:urfd_pkg::FRAC_BITS];
        over_limit    = (filt_int > urfd_pkg::INT_BITS'(limit))
                        || ((filt_int == urfd_pkg::INT_BITS'(limit))
                            && (|filtered_reg[urfd_pkg::FRAC_BITS-1:0]));
    end

    // tens and ones digits with leading-zero blanking
    always_comb
    begin
        blank_now = paused_reg || dark_reg;
        if (blank_now)
        begin
            shown = '0;
        end
        else if (value_reg > urfd_pkg::LIM_W'(urfd_pkg::MAX_SHOWN))
        begin
            shown = urfd_pkg::LIM_W'(urfd_pkg::MAX_SHOWN);
        end
        else
        begin
            shown = value_reg;
        end
        tens_prod = urfd_pkg::DIV10_W'(shown) * urfd_pkg::DIV10_W'(urfd_pkg::DIV10_MUL);
        tens      = urfd_pkg::DIGIT_W'(tens_prod >> urfd_pkg::DIV10_SHIFT);
        tens_x10  = urfd_pkg::LIM_W'({tens, 3'b000}) + urfd_pkg::LIM_W'({tens, 1'b0});
        ones      = urfd_pkg::DIGIT_W'(shown - tens_x10);
        tens_lit  = (tens != '0);
        ones_lit  = (ones != '0) || tens_lit;
    end

    assign emit_go = (state_reg == S_EMIT) && (!result_valid_reg || !result_stall);

    // sequencer, filter state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            paused_reg       <= 1'b0;
            phase_reg        <= PH_TRIG_LOW;
            phase_ticks_reg  <= '0;
            echo_ticks_reg   <= '0;
            filtered_reg     <= '0;
            dark_reg         <= 1'b1;
            value_reg        <= '0;
            trig_reg         <= 1'b0;
            fresh_reg        <= 1'b0;
            d_ge_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (result_valid_reg && !result_stall && !emit_go)
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (tick_valid)
                    begin
                        paused_reg      <= paused_next;
                        phase_reg       <= phase_next;
                        phase_ticks_reg <= phase_ticks_next;
                        echo_ticks_reg  <= echo_ticks_next;
                        dark_reg        <= dark_next;
                        trig_reg        <= trig_next;
                        fresh_reg       <= measure_done;
                        state_reg       <= measure_done ? S_RANGE : S_EMIT;
                    end
                end
                S_RANGE:
                begin
                    if (mul_done)
                    begin
                        d_ge_reg  <= d_ge;
                        state_reg <= S_FILTER;
                    end
                end
                S_FILTER:
                begin
                    if (mul_done)
                    begin
                        filtered_reg <= filtered_next;
                        state_reg    <= S_UPDATE;
                    end
                end
                S_UPDATE:
                begin
                    dark_reg  <= over_limit;
                    value_reg <= over_limit ? '0 : urfd_pkg::LIM_W'(filt_int);
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (emit_go)
                    begin
                        result_valid_reg           <= 1'b1;
                        result_reg.trigger         <= trig_reg;
                        result_reg.led             <= !paused_reg;
                        result_reg.new_reading     <= fresh_reg;
                        result_reg.blank           <= blank_now;
                        result_reg.shown_cm        <= shown;
                        result_reg.tens_segments   <= tens_lit ? urfd_pkg::seg_code(tens) : '0;
                        result_reg.ones_segments   <= ones_lit ? urfd_pkg::seg_code(ones) : '0;
                        result_reg.tens_on         <= tens_lit;
                        result_reg.ones_on         <= ones_lit;
                        state_reg                  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign tick_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // multiplier finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == S_RANGE || state_reg == S_FILTER))
        else $error("multiplier done outside a multiply wait");

    // an accepted transaction holds off the next one
    assert property (@(posedge clk) disable iff (!rst_n)
        (tick_valid && !tick_stall) |=> tick_stall)
        else $error("tick accepted twice without a result");

    // a loaded result is offered on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        emit_go |=> (result_valid && state_reg == S_IDLE))
        else $error("result not presented after load");

    // a finished measurement never coincides with a trigger pulse or pause
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.new_reading) |-> (!result.trigger && result.led))
        else $error("new reading with trigger high or paused");

endmodule

[dv/ultrasonic_range_filter_display_unit_tb.sv]
// ----------------------------------------------------------------------------
// ultrasonic_range_filter_display_unit_tb
// Self-checking bench for the echo ranging unit. Ticks go in over a
// valid/stall channel and each one is predicted by a behavioral copy of the
// trigger sequencer, echo counter, low-pass filter and display decode. Every
// display transaction is compared field by field in order. Directed tests
// cover register extremes, the limit edge, run/pause and long echoes.
// Random measurements then run under several idle and stall mixes.
// ----------------------------------------------------------------------------
module ultrasonic_range_filter_display_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // bench constants
    localparam int          RESET_CYCLES  = 12;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          TAIL_CYCLES   = 80;
    localparam int          QUIET_LIMIT   = 4000;
    localparam int          LONG_HOLD     = 400;
    localparam int          RANDOM_ITEMS  = 400;
    localparam int          REPORT_LIMIT  = 10;
    localparam int          CHANGE_W      = urfd_pkg::FILT_W + urfd_pkg::COEF_W;
    localparam logic [63:0] FILT_MAX      = (64'd1 << urfd_pkg::FILT_W) - 64'd1;

    // register values after reset
    localparam logic [urfd_pkg::COEF_W-1:0] INIT_SCALE = 16'd3378;
    localparam logic [urfd_pkg::COEF_W-1:0] INIT_GAIN  = 16'd655;
    localparam logic [urfd_pkg::LIM_W-1:0]  INIT_LIMIT = 7'd31;
    localparam logic [urfd_pkg::PH_W-1:0]   INIT_LOW   = 4'd2;
    localparam logic [urfd_pkg::PH_W-1:0]   INIT_HIGH  = 4'd10;

    // segment patterns of digits zero to nine
    localparam logic [urfd_pkg::SEG_W-1:0] DIGIT_SEGS [10] = '{
        8'h88, 8'hBE, 8'hC4, 8'hA4, 8'hB2, 8'hA1, 8'h83, 8'hBC, 8'h80, 8'hB0
    };

    typedef enum logic [1:0] {
        PING_LOW,
        PING_HIGH,
        PING_WAIT,
        PING_COUNT
    } ping_phase_t;

    // dut connections
    logic                           clk          = 1'b0;
    logic                           rst_n        = 1'b0;
    logic                           tick_valid   = 1'b0;
    logic                           tick_stall;
    urfd_pkg::tick_t                tick         = '0;
    logic                           result_valid;
    logic                           result_stall = 1'b0;
    urfd_pkg::result_t              result;
    logic                           cfg_we       = 1'b0;
    logic [urfd_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
    logic [urfd_pkg::CFG_W-1:0]     cfg_data     = '0;

    // ranger model: registers
    logic [urfd_pkg::COEF_W-1:0]     scale_q16;
    logic [urfd_pkg::COEF_W-1:0]     gain_q16;
    logic [urfd_pkg::LIM_W-1:0]      limit_cm;
    logic [urfd_pkg::PH_W-1:0]       low_len;
    logic [urfd_pkg::PH_W-1:0]       high_len;

    // ranger model: state
    logic                            run_paused;
    ping_phase_t                     ping_phase;
    logic [urfd_pkg::PH_W-1:0]       phase_count;
    logic [urfd_pkg::COUNT_BITS-1:0] echo_count;
    logic [urfd_pkg::FILT_W-1:0]     filter_q;
    logic [urfd_pkg::LIM_W-1:0]      shown_value;
    logic                            display_off;

    // displays still owed by the dut, oldest first
    urfd_pkg::result_t owed_displays [$];
    int unsigned       ticks_sent    = 0;
    int unsigned       failure_count = 0;
    int unsigned       send_idle_pct = 0;
    int unsigned       stall_pct     = 0;
    int unsigned       quiet_cycles  = 0;

    // long receiver hold-off, requested by toggling the token
    logic        hold_token = 1'b0;
    logic        hold_seen  = 1'b0;
    int unsigned hold_left  = 0;

    ultrasonic_range_filter_display_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .tick         (tick),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // ranger model
    // ------------------------------------------------------------------------

    function automatic void reset_ranger();
        scale_q16   = INIT_SCALE;
        gain_q16    = INIT_GAIN;
        limit_cm    = INIT_LIMIT;
        low_len     = INIT_LOW;
        high_len    = INIT_HIGH;
        run_paused  = 1'b0;
        ping_phase  = PING_LOW;
        phase_count = '0;
        echo_count  = '0;
        filter_q    = '0;
        shown_value = '0;
        display_off = 1'b1;
    endfunction

    function automatic void restart_ping();
        ping_phase  = PING_LOW;
        phase_count = '0;
        echo_count  = '0;
    endfunction

    // distance from the echo count, filter step, limit check
    function automatic void close_reading();
        logic [63:0]                 product;
        logic [63:0]                 dist_full;
        logic [urfd_pkg::FILT_W-1:0] dist_q;
        logic [CHANGE_W-1:0]         change;
        logic [urfd_pkg::LIM_W-1:0]  lim;
        logic [urfd_pkg::FILT_W-1:0] lim_q;
        product = 64'(echo_count) * 64'(scale_q16);
        if (urfd_pkg::FRAC_BITS >= 16)
            dist_full = product << (urfd_pkg::FRAC_BITS >= 16 ? urfd_pkg::FRAC_BITS - 16 : 0);
        else
            dist_full = product >> (urfd_pkg::FRAC_BITS < 16 ? 16 - urfd_pkg::FRAC_BITS : 0);
        dist_q = (dist_full > FILT_MAX) ? FILT_MAX[urfd_pkg::FILT_W-1:0]
                                        : dist_full[urfd_pkg::FILT_W-1:0];

        // step magnitude truncated toward zero in both directions
        if (dist_q >= filter_q)
        begin
            change   = CHANGE_W'(dist_q - filter_q);
            change   = change * CHANGE_W'(gain_q16);
            filter_q = filter_q + urfd_pkg::FILT_W'(change >> urfd_pkg::COEF_W);
        end
        else
        begin
            change   = CHANGE_W'(filter_q - dist_q);
            change   = change * CHANGE_W'(gain_q16);
            filter_q = filter_q - urfd_pkg::FILT_W'(change >> urfd_pkg::COEF_W);
        end

        lim   = (limit_cm > urfd_pkg::LIM_W'(urfd_pkg::MAX_SHOWN))
                ? urfd_pkg::LIM_W'(urfd_pkg::MAX_SHOWN) : limit_cm;
        lim_q = urfd_pkg::FILT_W'(lim);
        if (filter_q > (lim_q << urfd_pkg::FRAC_BITS))
        begin
            display_off = 1'b1;
            shown_value = '0;
        end
        else
        begin
            display_off = 1'b0;
            shown_value = urfd_pkg::LIM_W'(filter_q >> urfd_pkg::FRAC_BITS);
        end
    endfunction

    // advance the ranger by one tick and return the display it produces
    function automatic urfd_pkg::result_t step_ranger(input urfd_pkg::tick_t t);
        urfd_pkg::result_t          disp;
        logic [urfd_pkg::PH_W:0]    next_count;
        logic [urfd_pkg::PH_W-1:0]  phase_len;
        logic [urfd_pkg::LIM_W-1:0] shown;
        logic [3:0]                 tens;
        logic [3:0]                 ones;
        disp = '0;

        // a press toggles the mode before anything else
        if (t.button_press)
        begin
            run_paused = !run_paused;
            restart_ping();
            if (run_paused)
                display_off = 1'b1;
        end

        if (run_paused)
            restart_ping();
        else
        begin
            case (ping_phase)
                PING_LOW, PING_HIGH:
                begin
                    disp.trigger = (ping_phase == PING_HIGH);
                    phase_len    = disp.trigger ? high_len : low_len;
                    next_count   = {1'b0, phase_count} + 1'b1;
                    if (next_count >= {1'b0, phase_len})
                    begin
                        ping_phase  = disp.trigger ? PING_WAIT : PING_HIGH;
                        phase_count = '0;
                    end
                    else
                        phase_count = next_count[urfd_pkg::PH_W-1:0];
                end
                PING_WAIT:
                begin
                    if (t.echo)
                    begin
                        ping_phase = PING_COUNT;
                        echo_count = urfd_pkg::COUNT_BITS'(1);
                    end
                end
                default:
                begin
                    if (t.echo)
                    begin
                        if (echo_count != '1)
                            echo_count = echo_count + 1'b1;
                    end
                    else
                    begin
                        close_reading();
                        disp.new_reading = 1'b1;
                        restart_ping();
                    end
                end
            endcase
        end

        // display decode with leading-zero blanking
        disp.led   = !run_paused;
        disp.blank = run_paused || display_off;
        if (!disp.blank)
        begin
            shown         = (shown_value > urfd_pkg::LIM_W'(urfd_pkg::MAX_SHOWN))
                            ? urfd_pkg::LIM_W'(urfd_pkg::MAX_SHOWN) : shown_value;
            tens          = 4'(shown / 10);
            ones          = 4'(shown % 10);
            disp.shown_cm = shown;
            disp.tens_on  = (tens != 0);
            disp.ones_on  = (ones != 0) || (tens != 0);
            if (disp.tens_on)
                disp.tens_segments = DIGIT_SEGS[tens];
            if (disp.ones_on)
                disp.ones_segments = DIGIT_SEGS[ones];
        end
        return disp;
    endfunction

    // ------------------------------------------------------------------------
    // receiver side
    // ------------------------------------------------------------------------

    // random stall, or a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen    <= hold_token;
            hold_left    <= LONG_HOLD;
            result_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    function automatic string show_display(input urfd_pkg::result_t d);
        return $sformatf({"trig=%0b led=%0b new=%0b blank=%0b cm=%0d",
                          " tens=%h ones=%h ton=%0b oon=%0b"},
                         d.trigger, d.led, d.new_reading, d.blank, d.shown_cm,
                         d.tens_segments, d.ones_segments, d.tens_on, d.ones_on);
    endfunction

    function automatic void flag_failure(input string msg);
        failure_count++;
        if (failure_count <= REPORT_LIMIT)
            $display("%t ERROR %s", $realtime, msg);
    endfunction

    // compare each display transaction with the oldest owed display
    always @(posedge clk)
    begin
        urfd_pkg::result_t want;
        string             diffs;
        if (rst_n && result_valid && !result_stall)
        begin
            if (owed_displays.size() == 0)
                flag_failure({"display with no tick owed: ", show_display(result)});
            else
            begin
                want  = owed_displays.pop_front();
                diffs = "";
                if (result.trigger !== want.trigger)             diffs = {diffs, " trigger"};
                if (result.led !== want.led)                     diffs = {diffs, " led"};
                if (result.new_reading !== want.new_reading)     diffs = {diffs, " new_reading"};
                if (result.blank !== want.blank)                 diffs = {diffs, " blank"};
                if (result.shown_cm !== want.shown_cm)           diffs = {diffs, " shown_cm"};
                if (result.tens_segments !== want.tens_segments) diffs = {diffs, " tens_segments"};
                if (result.ones_segments !== want.ones_segments) diffs = {diffs, " ones_segments"};
                if (result.tens_on !== want.tens_on)             diffs = {diffs, " tens_on"};
                if (result.ones_on !== want.ones_on)             diffs = {diffs, " ones_on"};
                if (diffs != "")
                    flag_failure($sformatf("mismatch on%s\n  expected %s\n  actual   %s",
                                           diffs, show_display(want), show_display(result)));
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (tick_valid && !tick_stall) || (result_valid && !result_stall) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------

    function automatic urfd_pkg::tick_t tick_of(input logic echo_level, input logic press);
        urfd_pkg::tick_t t;
        t.echo         = echo_level;
        t.button_press = press;
        return t;
    endfunction

    // offer one tick, wait for the transaction, record the owed display
    task automatic send_tick(input urfd_pkg::tick_t t);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            tick_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        tick_valid <= 1'b1;
        tick       <= t;
        @(posedge clk);
        while (tick_stall)
            @(posedge clk);
        owed_displays.push_back(step_ranger(t));
        ticks_sent++;
    endtask

    // drop valid and wait until every owed display has come back
    task automatic settle_results();
        tick_valid <= 1'b0;
        while (owed_displays.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [urfd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [urfd_pkg::CFG_W-1:0]     data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            urfd_pkg::REG_RANGE_SCALE:  scale_q16 = data[urfd_pkg::COEF_W-1:0];
            urfd_pkg::REG_FILTER_GAIN:  gain_q16  = data[urfd_pkg::COEF_W-1:0];
            urfd_pkg::REG_BLANK_LIMIT:  limit_cm  = data[urfd_pkg::LIM_W-1:0];
            urfd_pkg::REG_TRIGGER_LOW:  low_len   = data[urfd_pkg::PH_W-1:0];
            urfd_pkg::REG_TRIGGER_HIGH: high_len  = data[urfd_pkg::PH_W-1:0];
            default:                    ;
        endcase
    endtask

    task automatic program_regs(input logic [urfd_pkg::CFG_W-1:0] scale, gain, limit,
                                lo_len, hi_len);
        settle_results();
        write_reg(urfd_pkg::REG_RANGE_SCALE, scale);
        write_reg(urfd_pkg::REG_FILTER_GAIN, gain);
        write_reg(urfd_pkg::REG_BLANK_LIMIT, limit);
        write_reg(urfd_pkg::REG_TRIGGER_LOW, lo_len);
        write_reg(urfd_pkg::REG_TRIGGER_HIGH, hi_len);
        cfg_we <= 1'b0;
    endtask

    // run (resuming if paused) until the ranger waits for echo
    task automatic reach_echo_wait();
        urfd_pkg::tick_t t;
        while (run_paused || ping_phase != PING_WAIT)
        begin
            t.button_press = run_paused;
            t.echo         = (ping_phase != PING_COUNT) && ($urandom_range(1) == 1);
            send_tick(t);
        end
    endtask

    // one well-formed measurement
    task automatic measure(input int unsigned idle_ticks, input int unsigned echo_len);
        reach_echo_wait();
        repeat (idle_ticks)
            send_tick(tick_of(1'b0, 1'b0));
        repeat (echo_len)
            send_tick(tick_of(1'b1, 1'b0));
        send_tick(tick_of(1'b0, 1'b0));
    endtask

    // mostly measurements, some cut short by a press, some noise
    task automatic random_session(input int unsigned n_items);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned echo_len;
        stop_at = ticks_sent + n_items;
        while (ticks_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
            begin
                pick     = $urandom_range(99);
                echo_len = (pick < 75) ? $urandom_range(20, 1) :
                           (pick < 95) ? $urandom_range(100, 21) : $urandom_range(2, 1);
                measure($urandom_range(3), echo_len);
            end
            else if (pick < 87)
            begin
                reach_echo_wait();
                repeat ($urandom_range(6, 1))
                    send_tick(tick_of(1'b1, 1'b0));
                send_tick(tick_of($urandom_range(1) == 1, 1'b1));
            end
            else
            begin
                repeat ($urandom_range(8, 1))
                    send_tick(urfd_pkg::tick_t'(2'($urandom)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // dark display before the first reading, filter landing exactly on the limit
    task automatic test_reset_state();
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (3)
            send_tick(tick_of(1'b1, 1'b0));
        // 2 ticks at 32769 from an empty filter gives exactly 1.0 cm
        program_regs(32769, 65535, 1, INIT_LOW, INIT_HIGH);
        measure(0, 2);
        // one more step puts it a fraction over the limit
        measure(0, 2);
        program_regs(INIT_SCALE, INIT_GAIN, INIT_LIMIT, INIT_LOW, INIT_HIGH);
        measure(2, 30);
    endtask

    // register extremes, unused indexes, two-digit and zero displays
    task automatic test_register_extremes();
        settle_results();
        for (int i = urfd_pkg::REG_TRIGGER_HIGH + 1; i < 2 ** urfd_pkg::CFG_IDX_W; i++)
            write_reg(urfd_pkg::CFG_IDX_W'(i), urfd_pkg::CFG_W'($urandom));
        cfg_we <= 1'b0;
        program_regs(65535, 65535, 99, 0, 0);
        measure(0, 11);
        measure(0, 99);
        measure(1, 100);
        // limit above 99 acts as 99
        program_regs(65535, 65535, 127, 15, 15);
        measure(0, 99);
        program_regs(65535, 65535, 0, 1, 1);
        measure(0, 1);
        // zero scale decays the filter to a shown zero
        program_regs(0, 65535, 5, 1, 15);
        measure(0, 3);
        measure(0, 3);
        // zero gain freezes the filter
        program_regs(65535, 0, 99, 15, 1);
        measure(2, 50);
    endtask

    // press in every phase, resume, double press
    task automatic test_run_pause();
        program_regs(40000, 40000, 99, 3, 3);
        measure(1, 40);
        send_tick(tick_of(1'b0, 1'b1));
        send_tick(tick_of(1'b1, 1'b0));
        send_tick(tick_of(1'b1, 1'b1));
        while (ping_phase != PING_HIGH)
            send_tick(tick_of(1'b0, 1'b0));
        send_tick(tick_of(1'b1, 1'b1));
        send_tick(tick_of(1'b0, 1'b1));
        reach_echo_wait();
        send_tick(tick_of(1'b0, 1'b1));
        send_tick(tick_of(1'b1, 1'b1));
        reach_echo_wait();
        repeat (3)
            send_tick(tick_of(1'b1, 1'b0));
        send_tick(tick_of(1'b1, 1'b1));
        send_tick(tick_of(1'b0, 1'b1));
        send_tick(tick_of(1'b0, 1'b1));
        measure(0, 25);
    endtask

    // long echo drives the filter far over the limit, then a short reading pulls down
    task automatic test_long_echo();
        program_regs(65535, 65535, 99, 1, 1);
        measure(0, 150);
        measure(0, 5);
    endtask

    // random measurements under each idle and stall mix and a fresh register set each half
    task automatic test_random_traffic();
        int unsigned send_mix  [4] = '{0, 50, 0, 33};
        int unsigned stall_mix [4] = '{0, 0, 50, 33};
        for (int m = 0; m < 4; m++)
        begin
            for (int half = 0; half < 2; half++)
            begin
                program_regs(urfd_pkg::CFG_W'($urandom), urfd_pkg::CFG_W'($urandom),
                             urfd_pkg::CFG_W'($urandom), urfd_pkg::CFG_W'($urandom),
                             urfd_pkg::CFG_W'($urandom));
                send_idle_pct = send_mix[m];
                stall_pct     = stall_mix[m];
                random_session(RANDOM_ITEMS / 8);
            end
        end
    endtask

    // long receiver hold-off while ticks keep coming, a full drain, then traffic under random stalls
    task automatic test_result_backpressure();
        program_regs(50000, 50000, 99, 1, 2);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_token   <= ~hold_token;
        measure(0, 30);
        settle_results();
        measure(1, 12);
        stall_pct = 33;
        random_session(60);
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial
    begin
        reset_ranger();
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_register_extremes();
        test_run_pause();
        test_long_echo();
        test_random_traffic();
        test_result_backpressure();

        settle_results();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (owed_displays.size() != 0)
            flag_failure($sformatf("%0d displays never came back", owed_displays.size()));
        if (failure_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[sim.f]
rtl/urfd_pkg.sv
rtl/urfd_serial_mul.sv
rtl/ultrasonic_range_filter_display_unit.sv
dv/ultrasonic_range_filter_display_unit_tb.sv
